// ===== hdl/gear_hash_chunk_splitter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// gear hash chunk splitter: assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is asserted
// ----------------------------------------------------------------------------
`ifndef GEAR_HASH_CHUNK_SPLITTER_UNIT_DEFINES_SVH
`define GEAR_HASH_CHUNK_SPLITTER_UNIT_DEFINES_SVH

// same-cycle implication
`define GHCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GHCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ghcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ghcs_pkg
// shared types, constants and the gear table of the chunk splitter
// ----------------------------------------------------------------------------
package ghcs_pkg;

	// default widths of length and offset/index counters
	localparam int LEN_BITS_DEF    = 24;
	localparam int OFFSET_BITS_DEF = 40;

	// fixed field widths
	localparam int HASH_W  = 24;
	localparam int CFG_W   = 24;
	localparam int IDENT_W = 32;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register reset values
	localparam logic [CFG_W-1:0] MIN_SIZE_RST = CFG_W'(2048);
	localparam logic [CFG_W-1:0] AVG_SIZE_RST = CFG_W'(8192);
	localparam logic [CFG_W-1:0] MAX_SIZE_RST = CFG_W'(65536);

	// gear table generator constants
	localparam logic [63:0] GEAR_SEED = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] GEAR_MULT = 64'h2545_f491_4f6c_dd1d;
	localparam int GEAR_DEPTH = 256;

	// register map, word index
	typedef enum logic [1:0] {
		REG_SPLIT_MODE = 2'd0,
		REG_MIN_SIZE   = 2'd1,
		REG_AVG_SIZE   = 2'd2,
		REG_MAX_SIZE   = 2'd3
	} reg_idx_t;

	// cutting modes
	typedef enum logic {
		MODE_CONTENT = 1'b0,
		MODE_FIXED   = 1'b1
	} split_mode_t;

	// configuration seen by the datapath
	typedef struct packed {
		split_mode_t       mode;
		logic [CFG_W-1:0]  min_size;
		logic [CFG_W-1:0]  avg_size;
		logic [CFG_W-1:0]  max_size;
		logic [HASH_W-1:0] hash_mask;
	} ghcs_cfg_t;

	typedef logic [HASH_W-1:0] gear_table_t [GEAR_DEPTH];

	// xorshift-multiply table, worked out at elaboration
	function automatic gear_table_t build_gear_table();
		logic [63:0] x;
		logic [63:0] p;
		gear_table_t t;
		x = GEAR_SEED;
		for (int i = 0; i < GEAR_DEPTH; i++) begin
			x = x ^ (x >> 12);
			x = x ^ (x << 25);
			x = x ^ (x >> 27);
			p = x * GEAR_MULT;
			t[i] = p[HASH_W-1:0];
		end
		return t;
	endfunction

	localparam gear_table_t GEAR_TABLE = build_gear_table();

	// mask of ceil_log2(max(2,avg))-1 low bits, at least one bit
	function automatic logic [HASH_W-1:0] avg_to_mask(input logic [CFG_W-1:0] avg);
		logic [CFG_W-1:0] s;
		s = (avg < CFG_W'(2)) ? CFG_W'(1) : avg - CFG_W'(1);
		s = s | (s >> 1);
		s = s | (s >> 2);
		s = s | (s >> 4);
		s = s | (s >> 8);
		s = s | (s >> 16);
		return HASH_W'(s >> 1) | HASH_W'(1);
	endfunction

endpackage

// ===== hdl/ghcs_if.sv =====
// ----------------------------------------------------------------------------
// ghcs channel interfaces
// valid/ready channels for input bytes and chunk reports
// ----------------------------------------------------------------------------
interface ghcs_byte_if
	import ghcs_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [7:0]         data_byte;
	logic               end_of_file;
	logic [IDENT_W-1:0] file_ident;

	modport source (output valid, data_byte, end_of_file, file_ident, input ready);
	modport sink   (input valid, data_byte, end_of_file, file_ident, output ready);
endinterface

interface ghcs_chunk_if
	import ghcs_pkg::*;
#(
	parameter int LEN_BITS    = LEN_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
)();
	logic                   valid;
	logic                   ready;
	logic [IDENT_W-1:0]     out_file_ident;
	logic [OFFSET_BITS-1:0] chunk_index;
	logic [OFFSET_BITS-1:0] chunk_offset;
	logic [LEN_BITS-1:0]    chunk_length;
	logic                   final_chunk;

	modport source (output valid, out_file_ident, chunk_index, chunk_offset, chunk_length,
		final_chunk, input ready);
	modport sink   (input valid, out_file_ident, chunk_index, chunk_offset, chunk_length,
		final_chunk, output ready);
endinterface

// ===== hdl/ghcs_cfg.sv =====
// ----------------------------------------------------------------------------
// ghcs_cfg
// APB register file holding mode and size settings, with the hash mask
// derived from the average size at write time
// ----------------------------------------------------------------------------
module ghcs_cfg
	import ghcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output ghcs_cfg_t          cfg
);

	ghcs_cfg_t cfg_q;
	reg_idx_t  reg_idx;
	logic      wr_en;

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_CONTENT;
			cfg_q.min_size  <= MIN_SIZE_RST;
			cfg_q.avg_size  <= AVG_SIZE_RST;
			cfg_q.max_size  <= MAX_SIZE_RST;
			cfg_q.hash_mask <= avg_to_mask(AVG_SIZE_RST);
		end else if (wr_en) begin
			case (reg_idx)
				REG_SPLIT_MODE: cfg_q.mode <= split_mode_t'(pwdata[0]);
				REG_MIN_SIZE:   cfg_q.min_size <= pwdata[CFG_W-1:0];
				REG_AVG_SIZE: begin
					cfg_q.avg_size  <= pwdata[CFG_W-1:0];
					cfg_q.hash_mask <= avg_to_mask(pwdata[CFG_W-1:0]);
				end
				REG_MAX_SIZE:   cfg_q.max_size <= pwdata[CFG_W-1:0];
				default:        cfg_q.mode <= cfg_q.mode;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		case (reg_idx)
			REG_SPLIT_MODE: prdata = PDATA_W'(cfg_q.mode);
			REG_MIN_SIZE:   prdata = PDATA_W'(cfg_q.min_size);
			REG_AVG_SIZE:   prdata = PDATA_W'(cfg_q.avg_size);
			REG_MAX_SIZE:   prdata = PDATA_W'(cfg_q.max_size);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== hdl/ghcs_core.sv =====
// ----------------------------------------------------------------------------
// ghcs_core
// input register, gear hash and cut decision, chunk state and result register
// ----------------------------------------------------------------------------
`include "gear_hash_chunk_splitter_unit_defines.svh"

module ghcs_core
	import ghcs_pkg::*;
#(
	parameter int LEN_BITS    = LEN_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
)(
	input  logic         clk,
	input  logic         arst_n,
	input  ghcs_cfg_t    cfg,
	ghcs_byte_if.sink    byte_in,
	ghcs_chunk_if.source chunk_out
);

	localparam int CMP_W = (LEN_BITS > CFG_W) ? LEN_BITS : CFG_W;
	localparam int SUM_W = ((OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS) + 1;
	localparam logic [LEN_BITS-1:0]    LEN_MAX = '1;
	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

	// input register
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               eof_s1;
	logic [IDENT_W-1:0] ident_s1;

	// chunk state
	logic [HASH_W-1:0]      hash_q;
	logic [LEN_BITS-1:0]    len_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic [OFFSET_BITS-1:0] count_q;

	// result register
	logic                   out_valid_q;
	logic [IDENT_W-1:0]     out_ident_q;
	logic [OFFSET_BITS-1:0] out_index_q;
	logic [OFFSET_BITS-1:0] out_offset_q;
	logic [LEN_BITS-1:0]    out_len_q;
	logic                   out_final_q;

	logic [HASH_W-1:0]      hash_next;
	logic [LEN_BITS-1:0]    len_inc;
	logic [CMP_W-1:0]       len_x;
	logic [CMP_W-1:0]       step_x;
	logic                   cut_content;
	logic                   cut_fixed;
	logic                   cut;
	logic                   emit;
	logic                   out_free;
	logic                   advance;
	logic                   accept;
	logic [SUM_W-1:0]       start_sum;
	logic [OFFSET_BITS-1:0] start_next;
	logic [OFFSET_BITS-1:0] count_next;

	// gear hash step and cut decision
	always_comb begin
		hash_next   = (hash_q << 1) + GEAR_TABLE[byte_s1];
		len_inc     = len_q + LEN_BITS'(1);
		len_x       = CMP_W'(len_inc);
		step_x      = (cfg.avg_size == '0) ? CMP_W'(1) : CMP_W'(cfg.avg_size);
		cut_content = ((len_x >= CMP_W'(cfg.min_size)) && ((hash_next & cfg.hash_mask) == '0))
			|| (len_x >= CMP_W'(cfg.max_size));
		cut_fixed   = len_x >= step_x;
		cut         = ((cfg.mode == MODE_FIXED) ? cut_fixed : cut_content)
			|| (len_inc == LEN_MAX);
		emit        = cut || eof_s1;
	end

	// saturating offset and index
	always_comb begin
		start_sum  = SUM_W'(start_q) + SUM_W'(len_inc);
		start_next = (start_sum > SUM_W'(OFF_MAX)) ? OFF_MAX : start_sum[OFFSET_BITS-1:0];
		count_next = (count_q == OFF_MAX) ? OFF_MAX : count_q + OFFSET_BITS'(1);
	end

	// handshake
	assign out_free      = !out_valid_q || chunk_out.ready;
	assign advance       = valid_s1 && (!emit || out_free);
	assign byte_in.ready = !valid_s1 || advance;
	assign accept        = byte_in.valid && byte_in.ready;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= byte_in.data_byte;
			eof_s1   <= byte_in.end_of_file;
			ident_s1 <= byte_in.file_ident;
		end
	end

	// chunk state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= '0;
			len_q   <= '0;
			start_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			if (eof_s1) begin
				hash_q  <= '0;
				len_q   <= '0;
				start_q <= '0;
				count_q <= '0;
			end else if (cut) begin
				hash_q  <= '0;
				len_q   <= '0;
				start_q <= start_next;
				count_q <= count_next;
			end else begin
				hash_q  <= hash_next;
				len_q   <= len_inc;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (chunk_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_ident_q  <= ident_s1;
			out_index_q  <= count_q;
			out_offset_q <= start_q;
			out_len_q    <= len_inc;
			out_final_q  <= eof_s1;
		end
	end

	assign chunk_out.valid          = out_valid_q;
	assign chunk_out.out_file_ident = out_ident_q;
	assign chunk_out.chunk_index    = out_index_q;
	assign chunk_out.chunk_offset   = out_offset_q;
	assign chunk_out.chunk_length   = out_len_q;
	assign chunk_out.final_chunk    = out_final_q;

	// checks
	`GHCS_ASSERT_NEXT(a_eof_clears, clk, arst_n, advance && eof_s1,
		len_q == '0 && start_q == '0 && count_q == '0 && hash_q == '0,
		"state not cleared after end of file")
	`GHCS_ASSERT_SAME(a_len_nonzero, clk, arst_n, out_valid_q, out_len_q != '0,
		"chunk reported with zero length")
	`GHCS_ASSERT_SAME(a_len_bound, clk, arst_n, 1'b1, len_q != LEN_MAX,
		"running length reached its limit without a cut")
	`GHCS_ASSERT_NEXT(a_hold_stalled, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(byte_s1) && $stable(eof_s1),
		"stalled input register lost its transaction")

endmodule

// ===== hdl/gear_hash_chunk_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// gear_hash_chunk_splitter_unit
// content-defined or fixed-size chunk boundary finder for byte streams
// ----------------------------------------------------------------------------
// Takes one file byte per clock and reports each chunk as file id, index,
// offset and length. The gear hash shift-add with its table lookup, the
// length compares and the saturating offset update all sit between the input
// register and the result register, so a byte is accepted on every cycle
// while the result side keeps up. A byte that closes a chunk needs the result
// register free; while a report waits there, bytes that close no chunk still
// pass. Sizes come from the APB registers; the user must change them only
// while the block is idle, and the block itself does not enforce it.
module gear_hash_chunk_splitter_unit
	import ghcs_pkg::*;
#(
	parameter int LEN_BITS    = LEN_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
)(
	input  logic               clk,
	input  logic               arst_n,
	ghcs_byte_if.sink          byte_in,
	ghcs_chunk_if.source       chunk_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	ghcs_cfg_t cfg;

	// configuration registers
	ghcs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// hashing and cutting datapath
	ghcs_core #(
		.LEN_BITS    (LEN_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.byte_in   (byte_in),
		.chunk_out (chunk_out)
	);

endmodule

// ===== dv/ghcs_chunk_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ghcs_chunk_checker
// watches the byte, chunk and register ports of the chunk splitter, works out
// the chunk reports that each accepted byte should cause and compares every
// accepted report, field by field, with the oldest one still outstanding
// ----------------------------------------------------------------------------
module ghcs_chunk_checker
	import ghcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	ghcs_byte_if               byte_mon,
	ghcs_chunk_if              chunk_mon,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);

	localparam int LB = LEN_BITS_DEF;
	localparam int OB = OFFSET_BITS_DEF;

	typedef struct packed {
		logic [IDENT_W-1:0] ident;
		logic [OB-1:0]      index;
		logic [OB-1:0]      offset;
		logic [LB-1:0]      length;
		logic               last;
	} chunk_report_t;

	// gear lookup, register copy and chunking state
	logic [HASH_W-1:0] gear_lut [GEAR_DEPTH];
	split_mode_t       mode_r;
	logic [CFG_W-1:0]  min_r;
	logic [CFG_W-1:0]  avg_r;
	logic [CFG_W-1:0]  max_r;
	logic [HASH_W-1:0] hash_r;
	logic [LB-1:0]     len_r;
	logic [OB-1:0]     start_r;
	logic [OB-1:0]     count_r;
	chunk_report_t     boundary_q [$];
	int                err_total;
	int                seen_total;

	// xorshift sequence, each step multiplied and cut to the hash width
	initial begin
		logic [63:0] x;
		logic [63:0] p;
		x = GEAR_SEED;
		for (int i = 0; i < GEAR_DEPTH; i++) begin
			x = x ^ (x >> 12);
			x = x ^ (x << 25);
			x = x ^ (x >> 27);
			p = x * GEAR_MULT;
			gear_lut[i] = p[HASH_W-1:0];
		end
	end

	// low bits of the hash that must be zero for a content cut
	function automatic logic [HASH_W-1:0] cut_mask(input logic [CFG_W-1:0] avg);
		int target;
		int bits;
		target = (avg < CFG_W'(2)) ? 2 : int'(avg);
		bits = 0;
		while (bits < 31 && (1 << bits) < target)
			bits++;
		bits = (bits > 1) ? bits - 1 : 1;
		if (bits > HASH_W)
			bits = HASH_W;
		return HASH_W'((1 << bits) - 1);
	endfunction

	function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] a, input logic [OB-1:0] b);
		logic [OB:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[OB] ? {OB{1'b1}} : s[OB-1:0];
	endfunction

	task automatic clear_chunking();
		hash_r  = '0;
		len_r   = '0;
		start_r = '0;
		count_r = '0;
	endtask

	// advance the hash and length by one byte, queue a report on a cut
	task automatic predict_boundary(input logic [7:0] b, input logic eof,
		input logic [IDENT_W-1:0] id);
		logic [LB-1:0]    nlen;
		logic [CFG_W-1:0] step;
		logic             cut;
		chunk_report_t    rep;
		hash_r = (hash_r << 1) + gear_lut[b];
		nlen = len_r + 1'b1;
		cut = 1'b0;
		if (mode_r == MODE_CONTENT) begin
			if (nlen >= min_r)
				cut = ((hash_r & cut_mask(avg_r)) == '0);
			if (nlen >= max_r)
				cut = 1'b1;
		end else begin
			step = (avg_r == '0) ? CFG_W'(1) : avg_r;
			if (nlen >= step)
				cut = 1'b1;
		end
		// length counter at its top value forces a cut
		if (nlen == '1)
			cut = 1'b1;
		if (!cut && !eof) begin
			len_r = nlen;
		end else begin
			rep.ident  = id;
			rep.index  = count_r;
			rep.offset = start_r;
			rep.length = nlen;
			rep.last   = eof;
			boundary_q.insert(boundary_q.size(), rep);
			if (eof) begin
				clear_chunking();
			end else begin
				start_r = sat_add(start_r, OB'(nlen));
				count_r = sat_add(count_r, OB'(1));
				len_r   = '0;
				hash_r  = '0;
			end
		end
	endtask

	task automatic check_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			err_total++;
		end
	endtask

	// register writes, report comparison, then byte prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r = MODE_CONTENT;
			min_r  = MIN_SIZE_RST;
			avg_r  = AVG_SIZE_RST;
			max_r  = MAX_SIZE_RST;
			clear_chunking();
			boundary_q.delete();
			err_total  = 0;
			seen_total = 0;
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_SPLIT_MODE: mode_r = split_mode_t'(pwdata[0]);
					REG_MIN_SIZE:   min_r  = pwdata[CFG_W-1:0];
					REG_AVG_SIZE:   avg_r  = pwdata[CFG_W-1:0];
					REG_MAX_SIZE:   max_r  = pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			if (chunk_mon.valid && chunk_mon.ready) begin
				seen_total++;
				if (boundary_q.size() == 0) begin
					$display("%0t: chunk report with none outstanding, expected nothing, actual ident %0h index %0h offset %0h length %0h last %0b",
						$time, chunk_mon.out_file_ident, chunk_mon.chunk_index,
						chunk_mon.chunk_offset, chunk_mon.chunk_length, chunk_mon.final_chunk);
					err_total++;
				end else begin
					check_field("out_file_ident", boundary_q[0].ident, chunk_mon.out_file_ident);
					check_field("chunk_index", boundary_q[0].index, chunk_mon.chunk_index);
					check_field("chunk_offset", boundary_q[0].offset, chunk_mon.chunk_offset);
					check_field("chunk_length", boundary_q[0].length, chunk_mon.chunk_length);
					check_field("final_chunk", boundary_q[0].last, chunk_mon.final_chunk);
					void'(boundary_q.pop_front());
				end
			end
			if (byte_mon.valid && byte_mon.ready)
				predict_boundary(byte_mon.data_byte, byte_mon.end_of_file, byte_mon.file_ident);
			fail_count <= err_total;
			pending    <= boundary_q.size();
			checked    <= seen_total;
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives file bytes and register settings into the chunk splitter: a short
// directed part over the size extremes, both modes and mid-file changes, then
// random files under three idling patterns with a long result stall; the
// checker beside the block predicts and compares every chunk report
// ----------------------------------------------------------------------------
module testbench;
	import ghcs_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_TAIL     = 4;
	localparam int PHASE_ITEMS    = 444;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int fail_count;
	int pending;
	int checked;
	int items_sent;
	int cfg_writes;
	int src_idle_pct;
	int snk_idle_pct;
	int quiet_cycles;
	int hold_req;
	int hold_ack;
	int hold_left;

	ghcs_byte_if  byte_ch ();
	ghcs_chunk_if chunk_ch ();

	gear_hash_chunk_splitter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_ch),
		.chunk_out (chunk_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	ghcs_chunk_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_mon   (byte_ch),
		.chunk_mon  (chunk_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side: random idling, or a long hold-off when requested
	always @(posedge clk) begin
		if (!arst_n) begin
			chunk_ch.ready <= 1'b0;
			hold_ack  = 0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			chunk_ch.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (hold_req != hold_ack) begin
			chunk_ch.ready <= 1'b0;
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES;
		end else begin
			chunk_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((byte_ch.valid && byte_ch.ready) || (chunk_ch.valid && chunk_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// offer one byte, with random gaps before it, and wait for acceptance
	task automatic send_byte(input logic [7:0] b, input logic eof, input logic [IDENT_W-1:0] id);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.data_byte   <= b;
		byte_ch.end_of_file <= eof;
		byte_ch.file_ident  <= id;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// stop offering and wait until every predicted report has arrived
	task automatic drain_results();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_writes++;
	endtask

	task automatic apply_config(input split_mode_t mode, input logic [CFG_W-1:0] min_size,
		input logic [CFG_W-1:0] avg_size, input logic [CFG_W-1:0] max_size);
		drain_results();
		apb_write(REG_SPLIT_MODE, PDATA_W'(mode));
		apb_write(REG_MIN_SIZE, PDATA_W'(min_size));
		apb_write(REG_AVG_SIZE, PDATA_W'(avg_size));
		apb_write(REG_MAX_SIZE, PDATA_W'(max_size));
	endtask

	// mostly small sizes, now and then an extreme or a full-range value
	function automatic logic [CFG_W-1:0] pick_size(input int small_hi);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r == 2)
			return CFG_W'($urandom);
		return CFG_W'($urandom_range(0, small_hi));
	endfunction

	// part of a file: random or flat content, stray id changes, eof if closed
	task automatic send_file(input int n, input logic close);
		logic [IDENT_W-1:0] id;
		logic [7:0]         fill;
		logic               flat;
		id   = $urandom;
		fill = $urandom;
		flat = ($urandom_range(0, 7) == 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				id = $urandom;
			send_byte(flat ? fill : 8'($urandom), close && (i == n - 1), id);
		end
	endtask

	// random files over changing settings under one idling pattern
	task automatic run_phase(input int n_items, input int src_pct, input int snk_pct,
		input logic long_hold);
		int stop_at;
		int seg_end;
		logic pause_due;
		split_mode_t mode;
		src_idle_pct = src_pct;
		snk_idle_pct <= snk_pct;
		stop_at = items_sent + n_items;
		// keep offering through the long hold so that the block fills up
		pause_due = !long_hold;
		while (items_sent < stop_at) begin
			mode = ($urandom_range(0, 9) < 7) ? MODE_CONTENT : MODE_FIXED;
			apply_config(mode, pick_size(24), pick_size(48), pick_size(96));
			if (long_hold) begin
				hold_req <= hold_req + 1;
				long_hold = 1'b0;
			end
			seg_end = items_sent + $urandom_range(40, 90);
			while (items_sent < seg_end && items_sent < stop_at) begin
				send_file(($urandom_range(0, 14) == 0) ? $urandom_range(100, 300) :
					$urandom_range(1, 40), $urandom_range(0, 7) != 0);
				// sender pause until the block has delivered everything
				if (pause_due) begin
					drain_results();
					pause_due = 1'b0;
				end
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n              <= 1'b0;
		byte_ch.valid       <= 1'b0;
		byte_ch.data_byte   <= '0;
		byte_ch.end_of_file <= 1'b0;
		byte_ch.file_ident  <= '0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		hold_req            <= 0;
		snk_idle_pct        <= 0;
		src_idle_pct = 0;
		items_sent   = 0;
		cfg_writes   = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest min and avg, largest max: byte and id extremes, id change without eof
		apply_config(MODE_CONTENT, '0, '0, '1);
		send_byte(8'h00, 1'b0, 32'h0000_0000);
		send_byte(8'hff, 1'b0, 32'h0000_0000);
		send_byte(8'h5a, 1'b0, 32'h0000_0007);
		send_byte(8'ha5, 1'b0, 32'h0000_0007);
		send_byte(8'h80, 1'b1, 32'hffff_ffff);

		// zero max size: every byte is a chunk of its own
		apply_config(MODE_CONTENT, '1, '1, '0);
		send_byte(8'h11, 1'b0, 32'h0000_0001);
		send_byte(8'h22, 1'b0, 32'h0000_0002);
		send_byte(8'h33, 1'b1, 32'h0000_0003);

		// fixed mode with zero step, then new step, then back to content mid-file
		apply_config(MODE_FIXED, '0, '0, '0);
		send_byte(8'h01, 1'b0, 32'h0000_0010);
		send_byte(8'hfe, 1'b0, 32'h0000_0010);
		apply_config(MODE_FIXED, 24'd5, 24'd3, 24'd9);
		for (int i = 0; i < 4; i++)
			send_byte(8'(i * 37), 1'b0, 32'h0000_0010);
		apply_config(MODE_CONTENT, 24'd1, 24'd2, 24'd4);
		send_byte(8'h7f, 1'b0, 32'h0000_0010);
		send_byte(8'h40, 1'b0, 32'h0000_0010);
		send_byte(8'hc3, 1'b1, 32'h0000_0010);

		// reset sizes with a one-byte file, then a cut and eof on the same byte
		apply_config(MODE_CONTENT, MIN_SIZE_RST, AVG_SIZE_RST, MAX_SIZE_RST);
		send_byte(8'h9d, 1'b1, 32'h8000_0000);
		apply_config(MODE_CONTENT, '0, 24'd2, 24'd1);
		send_byte(8'h2c, 1'b1, 32'h7fff_ffff);

		// random part under the three idling patterns
		run_phase(PHASE_ITEMS, 8, 85, 1'b0);
		run_phase(PHASE_ITEMS, 85, 8, 1'b0);
		run_phase(PHASE_ITEMS, 0, 0, 1'b1);

		drain_results();
		$display("covered %0d bytes over %0d register writes, both cutting modes and size extremes",
			items_sent, cfg_writes);
		$display("%0d chunk reports compared, %0d field errors", checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ghcs_pkg.sv
hdl/ghcs_if.sv
hdl/ghcs_cfg.sv
hdl/ghcs_core.sv
hdl/gear_hash_chunk_splitter_unit.sv
dv/ghcs_chunk_checker.sv
dv/testbench.sv
